// File: hw/rtl/rost_pkg.sv
// Shared constants, codes and word types of the rectangle overlap select table.
package rost_pkg;

   localparam int CAPACITY      = 32;
   localparam int COORD_BITS    = 16;
   localparam int KEY_BITS      = 32;
   localparam int STATUS_BITS   = 3;
   localparam int IDX_BITS      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS      = $clog2(CAPACITY + 1);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SELECT = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NULL     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_NOCTRL   = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd1;
   localparam logic [1:0] AXIS_Y = 2'd2;

   localparam logic REG_AXIS_MODE     = 1'b0;
   localparam logic REG_CTRL_ATTACHED = 1'b1;

   typedef struct packed {
      logic [1:0]                   req_type;
      logic [KEY_BITS-1:0]          item_key;
      logic signed [COORD_BITS-1:0] corner_a_x;
      logic signed [COORD_BITS-1:0] corner_a_y;
      logic signed [COORD_BITS-1:0] corner_b_x;
      logic signed [COORD_BITS-1:0] corner_b_y;
   } req_word_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]    match_key;
      logic                   matched;
      logic                   last_result;
      logic [STATUS_BITS-1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]          key;
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] top;
      logic signed [COORD_BITS-1:0] bottom;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [1:0] {
      WR_NONE,
      WR_NEW_LAST,
      WR_NEW_COUNT,
      WR_COPY
   } wr_kind_type;

   typedef struct packed {
      logic                   load;
      logic                   rd_scan;
      logic                   rd_last;
      wr_kind_type            wr_kind;
      logic                   cnt_inc;
      logic                   cnt_dec;
      logic                   emit;
      logic [STATUS_BITS-1:0] emit_status;
      logic                   sel_end;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       key_null;
      logic       live;
      logic       count_zero;
      logic       full;
      logic       found;
      logic       slot_is_last;
      logic       scan_last;
   } dp_stat_type;

endpackage

// File: hw/rtl/rost_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rost_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rost_csr.sv
// Configuration registers behind the APB-style port.
module rost_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rost_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [rost_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [rost_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready,
   output logic [1:0]                         axis_mode,
   output logic                               ctrl_attached
);
   import rost_pkg::*;

   logic [1:0] axis_mode_ff, axis_mode_in;
   logic       ctrl_attached_ff, ctrl_attached_in;
   logic       wr_hit;
   logic       reg_index;

   assign reg_index = paddr[2];
   assign wr_hit    = psel & penable & pwrite;

   always_comb begin
      axis_mode_in     = axis_mode_ff;
      ctrl_attached_in = ctrl_attached_ff;
      if (wr_hit) begin
         unique case (reg_index)
            REG_AXIS_MODE:     axis_mode_in     = pwdata[1:0];
            REG_CTRL_ATTACHED: ctrl_attached_in = pwdata[0];
            default:           axis_mode_in     = axis_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_mode_ff     <= '0;
         ctrl_attached_ff <= 1'b0;
      end else begin
         axis_mode_ff     <= axis_mode_in;
         ctrl_attached_ff <= ctrl_attached_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_AXIS_MODE:     prdata[1:0] = axis_mode_ff;
         REG_CTRL_ATTACHED: prdata[0]   = ctrl_attached_ff;
         default:           prdata      = '0;
      endcase
   end

   assign pready        = 1'b1;
   assign axis_mode     = axis_mode_ff;
   assign ctrl_attached = ctrl_attached_ff;

endmodule

// File: hw/rtl/rost_datapath.sv
// Datapath: request registers, entry memory, scan address, overlap test and result register.
module rost_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  rost_pkg::req_word_type req_word,
   input  logic [1:0]             axis_mode,
   input  rost_pkg::dp_cmd_type   cmd,
   output rost_pkg::dp_stat_type  stat,
   output logic                   rsp_strobe,
   output rost_pkg::rsp_word_type rsp_word
);
   import rost_pkg::*;

   logic [1:0]                   op_ff, op_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic signed [COORD_BITS-1:0] ql_ff, ql_in, qr_ff, qr_in;
   logic signed [COORD_BITS-1:0] qt_ff, qt_in, qb_ff, qb_in;
   logic [CNT_BITS-1:0]          count_ff, count_in, count_m1;
   logic [IDX_BITS-1:0]          addr_ff, addr_in;
   logic                         rd_scan_ff, rd_scan_in;
   logic [IDX_BITS-1:0]          rd_idx_ff, rd_idx_in;
   logic                         found_ff, found_in;
   logic [IDX_BITS-1:0]          slot_ff, slot_in;
   logic                         pend_ff, pend_in;
   logic [KEY_BITS-1:0]          pend_key_ff, pend_key_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;

   logic                  wr_en, rd_en;
   logic [IDX_BITS-1:0]   wr_addr, rd_addr;
   logic [ENTRY_BITS-1:0] wr_data, rd_data;
   entry_type             rd_entry, new_entry;
   logic                  x_hit, y_hit, area_ok, hit, live;

   assign count_m1  = count_ff - CNT_BITS'(1);
   assign rd_entry  = entry_type'(rd_data);
   assign new_entry = '{key: key_ff, left: ql_ff, right: qr_ff, top: qt_ff, bottom: qb_ff};

   // Strict overlap of a stored rectangle with the query.
   assign x_hit   = (rd_entry.left < qr_ff) && (rd_entry.right > ql_ff);
   assign y_hit   = (rd_entry.top < qb_ff) && (rd_entry.bottom > qt_ff);
   assign area_ok = (rd_entry.right > rd_entry.left) && (rd_entry.bottom > rd_entry.top);

   always_comb begin
      if (axis_mode == AXIS_X) begin
         hit  = x_hit;
         live = ql_ff < qr_ff;
      end else if (axis_mode == AXIS_Y) begin
         hit  = y_hit;
         live = qt_ff < qb_ff;
      end else begin
         hit  = area_ok & x_hit & y_hit;
         live = (ql_ff < qr_ff) && (qt_ff < qb_ff);
      end
   end

   assign stat.op           = op_ff;
   assign stat.key_null     = (key_ff == '0);
   assign stat.live         = live;
   assign stat.count_zero   = (count_ff == '0);
   assign stat.full         = (count_ff == CNT_BITS'(CAPACITY));
   assign stat.found        = found_ff;
   assign stat.slot_is_last = ((CNT_BITS'(slot_ff) + CNT_BITS'(1)) == count_ff);
   assign stat.scan_last    = ((CNT_BITS'(addr_ff) + CNT_BITS'(1)) == count_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = new_entry;
      unique case (cmd.wr_kind)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_NEW_LAST: begin
            wr_en   = 1'b1;
            wr_addr = count_m1[IDX_BITS-1:0];
         end
         WR_NEW_COUNT: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[IDX_BITS-1:0];
         end
         WR_COPY: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rd_en   = cmd.rd_scan | cmd.rd_last;
   assign rd_addr = cmd.rd_last ? count_m1[IDX_BITS-1:0] : addr_ff;

   rost_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      qt_in        = qt_ff;
      qb_in        = qb_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_scan_in   = cmd.rd_scan;
      rd_idx_in    = addr_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      pend_in      = pend_ff;
      pend_key_in  = pend_key_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;

      if (cmd.load) begin
         op_in    = req_word.req_type;
         key_in   = req_word.item_key;
         ql_in    = (req_word.corner_a_x < req_word.corner_b_x) ?
                    req_word.corner_a_x : req_word.corner_b_x;
         qr_in    = (req_word.corner_a_x < req_word.corner_b_x) ?
                    req_word.corner_b_x : req_word.corner_a_x;
         qt_in    = (req_word.corner_a_y < req_word.corner_b_y) ?
                    req_word.corner_a_y : req_word.corner_b_y;
         qb_in    = (req_word.corner_a_y < req_word.corner_b_y) ?
                    req_word.corner_b_y : req_word.corner_a_y;
         addr_in  = '0;
         found_in = 1'b0;
         pend_in  = 1'b0;
      end

      if (cmd.rd_scan) begin
         addr_in = addr_ff + IDX_BITS'(1);
      end

      // A match is held back until the next match or the end of the scan so that the final one can be flagged as last.
      if (rd_scan_ff) begin
         if (op_ff == OP_SELECT) begin
            if (hit) begin
               if (pend_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_word_in.match_key   = pend_key_ff;
                  rsp_word_in.matched     = 1'b1;
                  rsp_word_in.last_result = 1'b0;
                  rsp_word_in.status      = ST_OK;
               end
               pend_in     = 1'b1;
               pend_key_in = rd_entry.key;
            end
         end else if (rd_entry.key == key_ff) begin
            found_in = 1'b1;
            slot_in  = rd_idx_ff;
         end
      end

      if (cmd.sel_end) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.match_key   = pend_ff ? pend_key_ff : '0;
         rsp_word_in.matched     = pend_ff;
         rsp_word_in.last_result = 1'b1;
         rsp_word_in.status      = ST_OK;
         pend_in                 = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.match_key   = '0;
         rsp_word_in.matched     = 1'b0;
         rsp_word_in.last_result = 1'b1;
         rsp_word_in.status      = cmd.emit_status;
      end

      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_scan_ff   <= 1'b0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_scan_ff   <= rd_scan_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      ql_ff       <= ql_in;
      qr_ff       <= qr_in;
      qt_ff       <= qt_in;
      qb_ff       <= qb_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      slot_ff     <= slot_in;
      pend_key_ff <= pend_key_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// File: hw/rtl/rost_ctrl.sv
// Controller state machine that sequences lookups, scans, slot moves and results.
module rost_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  ctrl_attached,
   input  rost_pkg::dp_stat_type stat,
   output rost_pkg::dp_cmd_type  cmd,
   output logic                  busy
);
   import rost_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_COPY,
      S_WRNEW
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      is_update;

   assign is_update = (stat.op == OP_INSERT) || (stat.op == OP_REMOVE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (is_update && stat.key_null) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_NULL;
               state_in        = S_IDLE;
            end else if (stat.op == OP_SELECT && !ctrl_attached) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_NOCTRL;
               state_in        = S_IDLE;
            end else if (stat.op == OP_SELECT && (!stat.live || stat.count_zero)) begin
               cmd.sel_end = 1'b1;
               state_in    = S_IDLE;
            end else if (!is_update && stat.op != OP_SELECT) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
            end else if (stat.count_zero) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (stat.op == OP_SELECT) begin
               cmd.sel_end = 1'b1;
               state_in    = S_IDLE;
            end else if (!stat.found) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
               priority if (stat.op == OP_REMOVE) begin
                  cmd.emit_status = ST_NOTFOUND;
               end else if (stat.full) begin
                  cmd.emit_status = ST_FULL;
               end else begin
                  cmd.emit_status = ST_OK;
                  cmd.wr_kind     = WR_NEW_COUNT;
                  cmd.cnt_inc     = 1'b1;
               end
            end else if (stat.slot_is_last) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
               if (stat.op == OP_REMOVE) begin
                  cmd.cnt_dec = 1'b1;
               end else begin
                  cmd.wr_kind = WR_NEW_LAST;
               end
            end else begin
               cmd.rd_last = 1'b1;
               state_in    = S_COPY;
            end
         end
         S_COPY: begin
            cmd.wr_kind = WR_COPY;
            if (stat.op == OP_REMOVE) begin
               cmd.cnt_dec     = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
            end else begin
               state_in = S_WRNEW;
            end
         end
         S_WRNEW: begin
            cmd.wr_kind     = WR_NEW_LAST;
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_OK;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy_in = (state_in != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// File: hw/rtl/rect_overlap_select_table.sv
// Top level of the rectangle overlap select table.
// A request word is taken when start is high and busy is low; busy then stays high until
// the request is finished. Insert, remove and select walk the stored entries through the
// single read port of the entry memory, one entry per cycle. A refused request, an unused
// request type or a select that cannot match anything ends without a scan, as does an
// insert or remove into an empty table; a remove or an update of an entry that is not in
// the last slot also moves the last entry into that slot. The final result word is on the
// ports in the same cycle in which busy falls, and the next request word can be taken in
// that same cycle. Results appear on rsp_word, each marked by rsp_strobe for a single cycle,
// and cannot be held off; a select gives one word per matching entry in slot order, the last
// one flagged, or a single empty word when nothing matches.
module rect_overlap_select_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rost_pkg::req_word_type             req_word,
   output logic                               rsp_strobe,
   output rost_pkg::rsp_word_type             rsp_word,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rost_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [rost_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [rost_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import rost_pkg::*;

   logic [1:0]  axis_mode;
   logic        ctrl_attached;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   rost_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .axis_mode     (axis_mode),
      .ctrl_attached (ctrl_attached)
   );

   rost_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .ctrl_attached (ctrl_attached),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   rost_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .axis_mode  (axis_mode),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
